### rtl/rpn_stack_calculator_core_assert.svh
// Assertion macros shared by the calculator RTL.
// Both are clocked on clk and held off while arst_n is low.
`ifndef RPN_STACK_CALCULATOR_CORE_ASSERT_SVH
`define RPN_STACK_CALCULATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPN_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/rpn_pkg.sv
package rpn_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 16;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned DEPTH_OUT_W = 5;
	localparam int unsigned DIV_STEPS = 32;

	typedef enum logic [2:0] {
		CMD_PUSH = 3'd0,
		CMD_ADD  = 3'd1,
		CMD_SUB  = 3'd2,
		CMD_MUL  = 3'd3,
		CMD_DIV  = 3'd4,
		CMD_DROP = 3'd5,
		CMD_DUP  = 3'd6,
		CMD_SWAP = 3'd7
	} calc_cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FEW  = 2'd1,
		ST_FULL = 2'd2,
		ST_DIVZ = 2'd3
	} calc_status_t;

	typedef struct packed {
		calc_cmd_t                  cmd;
		logic signed [DATA_W-1:0]   operand_value;
	} calc_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]   top_value;
		logic [DEPTH_OUT_W-1:0]     stack_depth;
		calc_status_t               status;
	} calc_rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_DONE
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic commit;
		logic div_start;
		logic div_commit;
		logic out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_go;
		logic div_done;
	} dp_stat_t;

endpackage

### rtl/rpn_div.sv
module rpn_div import rpn_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DATA_W-1:0] dividend,
	input  logic signed [DATA_W-1:0] divisor,
	output logic                     done,
	output logic signed [DATA_W-1:0] quotient
);

	localparam int unsigned CNT_W = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dvs_q;
	logic              neg_q;

	logic [DATA_W-1:0] a_abs;
	logic [DATA_W-1:0] b_abs;
	logic [DATA_W:0]   rem_shift;
	logic [DATA_W:0]   trial;
	logic              fits;

	always_comb begin
		a_abs     = dividend[DATA_W-1] ? DATA_W'(-dividend) : DATA_W'(dividend);
		b_abs     = divisor[DATA_W-1] ? DATA_W'(-divisor) : DATA_W'(divisor);
		rem_shift = {rem_q, quo_q[DATA_W-1]};
		trial     = rem_shift - {1'b0, dvs_q};
		fits      = rem_shift >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring division on magnitudes, one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= a_abs;
			rem_q <= '0;
			dvs_q <= b_abs;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			quo_q <= {quo_q[DATA_W-2:0], fits};
			rem_q <= fits ? trial[DATA_W-1:0] : rem_shift[DATA_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

### rtl/rpn_dp.sv
module rpn_dp import rpn_pkg::*; #(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  calc_req_t req,
	input  dp_cmd_t   ctl,
	output dp_stat_t  stat,
	output calc_rsp_t rsp
);

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
	localparam logic [DW-1:0] FULL_D = DW'(STACK_DEPTH);

	// The top element lives in top_q; the memory holds the elements below it.
	logic signed [DATA_W-1:0] mem [STACK_DEPTH];

	calc_req_t                req_q;
	logic signed [DATA_W-1:0] top_q;
	logic signed [DATA_W-1:0] rd_data_q;
	logic [DW-1:0]            depth_q;
	calc_status_t             status_q;
	calc_rsp_t                rsp_q;

	logic [DW-1:0]            d_dec;
	logic [DW-1:0]            d_inc;
	logic [DW-1:0]            d_sub2;
	logic [AW-1:0]            rd_addr;
	logic                     has1;
	logic                     has2;
	logic                     full;
	logic signed [DATA_W-1:0] prod_lo;
	calc_status_t             op_st;
	logic signed [DATA_W-1:0] op_top;
	logic [DW-1:0]            op_depth;
	logic                     op_wr;
	logic [AW-1:0]            op_wa;
	logic                     div_go;
	logic                     div_done;
	logic signed [DATA_W-1:0] quotient;
	logic [DW+DEPTH_OUT_W-1:0] depth_ext;

	rpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (rd_data_q),
		.divisor  (top_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		d_dec     = depth_q - DW'(1);
		d_inc     = depth_q + DW'(1);
		d_sub2    = depth_q - DW'(2);
		rd_addr   = d_sub2[AW-1:0];
		has1      = depth_q != '0;
		has2      = depth_q >= DW'(2);
		full      = depth_q == FULL_D;
		// Only the low half of the product is kept, so a 32-bit product suffices.
		prod_lo   = rd_data_q * top_q;

		op_st    = ST_OK;
		op_top   = top_q;
		op_depth = depth_q;
		op_wr    = 1'b0;
		op_wa    = d_dec[AW-1:0];
		div_go   = 1'b0;

		case (req_q.cmd)
			CMD_PUSH: begin
				if (full) begin
					op_st = ST_FULL;
				end else begin
					op_top   = req_q.operand_value;
					op_depth = d_inc;
					op_wr    = has1;
				end
			end
			CMD_DUP: begin
				if (!has1) begin
					op_st = ST_FEW;
				end else if (full) begin
					op_st = ST_FULL;
				end else begin
					op_depth = d_inc;
					op_wr    = 1'b1;
				end
			end
			default: begin
				if (!has2) begin
					op_st = ST_FEW;
				end else begin
					case (req_q.cmd)
						CMD_ADD: begin
							op_top   = rd_data_q + top_q;
							op_depth = d_dec;
						end
						CMD_SUB: begin
							op_top   = rd_data_q - top_q;
							op_depth = d_dec;
						end
						CMD_MUL: begin
							op_top   = prod_lo;
							op_depth = d_dec;
						end
						CMD_DIV: begin
							if (top_q == '0) begin
								op_st = ST_DIVZ;
							end else begin
								div_go = 1'b1;
							end
						end
						CMD_DROP: begin
							op_top   = rd_data_q;
							op_depth = d_dec;
						end
						CMD_SWAP: begin
							op_top = rd_data_q;
							op_wr  = 1'b1;
							op_wa  = rd_addr;
						end
						default: begin
							op_st = ST_OK;
						end
					endcase
				end
			end
		endcase
	end

	assign stat.div_go   = div_go;
	assign stat.div_done = div_done;

	// The second element is read every cycle, so it is ready when a command arrives.
	always_ff @(posedge clk) begin
		if (ctl.commit && op_wr) begin
			mem[op_wa] <= top_q;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= '0;
			status_q <= ST_OK;
		end else begin
			if (ctl.commit) begin
				depth_q <= op_depth;
			end else if (ctl.div_commit) begin
				depth_q <= d_dec;
			end
			if (ctl.commit || ctl.div_start) begin
				status_q <= op_st;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q <= req;
		end
		if (ctl.commit) begin
			top_q <= op_top;
		end else if (ctl.div_commit) begin
			top_q <= quotient;
		end
		if (ctl.out_load) begin
			rsp_q.top_value   <= has1 ? top_q : '0;
			rsp_q.stack_depth <= depth_ext[DEPTH_OUT_W-1:0];
			rsp_q.status      <= status_q;
		end
	end

	assign depth_ext = {{DEPTH_OUT_W{1'b0}}, depth_q};
	assign rsp       = rsp_q;

endmodule

### rtl/rpn_ctrl.sv
module rpn_ctrl import rpn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  ctl
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        rsp_valid_q;
	logic        out_free;

	assign out_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.div_go) begin
					ctl.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					ctl.commit = 1'b1;
					state_d    = S_DONE;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					ctl.div_commit = 1'b1;
					state_d        = S_DONE;
				end
			end
			S_DONE: begin
				// Hold the result until the output register has room.
				if (out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

### rtl/rpn_stack_calculator_core.sv
// Integer reverse-Polish calculator on a stack of up to STACK_DEPTH signed 32-bit
// elements. Each transaction on req carries a command and an operand, and yields
// exactly one transaction on rsp with the new top, depth and status. Commands are
// taken one at a time: push, add, subtract, multiply, drop, duplicate and swap
// use the registered read of the second element from the stack memory and the
// write-back of the result. A divide that goes ahead waits for the divider, which
// produces one quotient bit a cycle; a divide refused for too few operands or a
// zero divisor takes the same path as the others. A result waiting in the output
// register does not hold up the next command; only the following result waits
// until rsp is taken.
// The stack needs no clearing after reset.
`include "rpn_stack_calculator_core_assert.svh"

module rpn_stack_calculator_core import rpn_pkg::*; #(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  calc_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output calc_rsp_t rsp
);

	dp_cmd_t  ctl;
	dp_stat_t stat;

	rpn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	rpn_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.stat   (stat),
		.rsp    (rsp)
	);

	`RPN_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready while busy")
	`RPN_ASSERT_NEXT(a_div_not_instant, ctl.div_start, !stat.div_done, "divider done at once")
	`RPN_ASSERT_SAME(a_no_overwrite, ctl.out_load, !rsp_valid || rsp_ready, "result overwritten")

endmodule
